>>> rtl/s256sh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package s256sh_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned HASH_WORDS = 8;
    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned BLOCK_W    = 512;
    localparam int unsigned FILL_W     = 6;
    localparam int unsigned LEN_W      = 64;

    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [7:0]  PAD_ZERO   = 8'h00;
    localparam logic [WORD_W-1:0] LEN_STEP = 32'd8;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t HASH_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 of a byte stream. Each input transfer carries at most one message byte
// (tuser = byte present) and tlast closes the message, with or without a byte. A byte
// that does not complete a 64-byte block nor close the message leaves s_axis_tready high.
// The 64th byte of a block starts the compression, a single round unit reused once per
// cycle: 64 rounds and then the chaining update, while s_axis_tready is low. At the end
// of a message, padding and the length go into the block one byte per cycle outside the
// compressions, with two compressions when the tail leaves no room for the length, then
// the digest leaves as eight 32-bit transfers, word 0 first, tlast on word 7. The block
// then starts over for the next message.
module sha256_stream_hasher_unit
    import s256sh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    input  wire logic        s_axis_tuser,   // [0] byte_present
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output      logic        m_axis_tlast,
    output      logic [2:0]  m_axis_tuser    // [2:0] word_number
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t                   state_reg,   state_next;
    word_t                    hash_reg     [HASH_WORDS];
    word_t                    hash_next    [HASH_WORDS];
    word_t                    work_reg     [HASH_WORDS];
    word_t                    work_next    [HASH_WORDS];
    logic [BLOCK_W-1:0]       blk_reg,     blk_next;
    logic [LEN_W-1:0]         len_reg,     len_next;
    logic [FILL_W-1:0]        fill_reg,    fill_next;
    logic [5:0]               round_reg,   round_next;
    logic [2:0]               word_reg,    word_next;
    logic                     ending_reg,  ending_next;
    logic                     mark_reg,    mark_next;
    logic                     extra_reg,   extra_next;
    logic                     final_reg,   final_next;

    logic                     in_xfer;
    logic                     out_xfer;
    logic [7:0]               pad_byte;
    logic                     len_zone;
    word_t                    w0, w1, w9, w14, w_new;
    word_t                    t1, t2;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = hash_reg[0];
    assign m_axis_tuser  = word_reg;
    assign m_axis_tlast  = (word_reg == 3'd7);

    assign w0  = blk_reg[BLOCK_W-1      -: WORD_W];
    assign w1  = blk_reg[BLOCK_W-1-32   -: WORD_W];
    assign w9  = blk_reg[BLOCK_W-1-288  -: WORD_W];
    assign w14 = blk_reg[BLOCK_W-1-448  -: WORD_W];
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + w0;
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    // Length bytes go in only once the block holding the mark leaves room for them
    assign len_zone = mark_reg && !extra_reg && (fill_reg[5:3] == 3'b111);
    assign pad_byte = !mark_reg ? PAD_MARK : (len_zone ? len_reg[LEN_W-1 -: 8] : PAD_ZERO);

    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        work_next   = work_reg;
        blk_next    = blk_reg;
        len_next    = len_reg;
        fill_next   = fill_reg;
        round_next  = round_reg;
        word_next   = word_reg;
        ending_next = ending_reg;
        mark_next   = mark_reg;
        extra_next  = extra_reg;
        final_next  = final_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ending_next = s_axis_tlast;
                    mark_next   = 1'b0;
                    extra_next  = 1'b0;
                    final_next  = 1'b0;
                    if (s_axis_tuser)
                    begin
                        blk_next  = {blk_reg[BLOCK_W-9:0], s_axis_tdata};
                        len_next  = len_reg + {32'd0, LEN_STEP};
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            work_next  = hash_reg;
                            round_next = '0;
                            state_next = ST_ROUND;
                        end
                        else if (s_axis_tlast)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                blk_next  = {blk_reg[BLOCK_W-9:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next  = 1'b1;
                    extra_next = (fill_reg[5:3] == 3'b111);
                end
                if (len_zone)
                begin
                    len_next = {len_reg[LEN_W-9:0], 8'd0};
                end
                if (fill_reg == 6'd63)
                begin
                    final_next = len_zone;
                    work_next  = hash_reg;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                blk_next     = {blk_reg[BLOCK_W-WORD_W-1:0], w_new};
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                extra_next = 1'b0;
                word_next  = '0;
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (ending_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT:
            begin
                if (out_xfer)
                begin
                    for (int i = 0; i < HASH_WORDS - 1; i++)
                    begin
                        hash_next[i] = hash_reg[i+1];
                    end
                    hash_next[HASH_WORDS-1] = hash_reg[0];
                    word_next = word_reg + 3'd1;
                    if (word_reg == 3'd7)
                    begin
                        hash_next   = HASH_INIT;
                        len_next    = '0;
                        fill_next   = '0;
                        ending_next = 1'b0;
                        mark_next   = 1'b0;
                        final_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hash_reg   <= HASH_INIT;
            len_reg    <= '0;
            fill_reg   <= '0;
            round_reg  <= '0;
            word_reg   <= '0;
            ending_reg <= 1'b0;
            mark_reg   <= 1'b0;
            extra_reg  <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            len_reg    <= len_next;
            fill_reg   <= fill_next;
            round_reg  <= round_next;
            word_reg   <= word_next;
            ending_reg <= ending_next;
            mark_reg   <= mark_next;
            extra_reg  <= extra_next;
            final_reg  <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

endmodule

`default_nettype wire
